// ===== design/ptce_pkg.sv =====
// Shared constants, register map, configuration and control types for the pedal torque encoder.
`default_nettype none
package ptce_pkg;

  localparam int ADC_BITS_DEF   = 12;
  localparam int FIELD_BITS_DEF = 16;

  localparam int LEVEL_W    = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [LEVEL_W-1:0] Q16_ONE = 17'h10000;

  localparam int DIV_QBITS         = 16;
  localparam int DIV_BITS_PER_STEP = 4;
  localparam int DIV_STEPS         = DIV_QBITS / DIV_BITS_PER_STEP;
  localparam int DIV_CNT_W         = $clog2(DIV_STEPS);

  localparam logic [11:0]        RST_ADC_LOW     = 12'd1025;
  localparam logic [11:0]        RST_ADC_HIGH    = 12'd3215;
  localparam logic [16:0]        RST_FILTER_GAIN = 17'd6554;
  localparam logic [15:0]        RST_ENABLE      = 16'd1311;
  localparam logic [15:0]        RST_FULL_TORQUE = 16'd533;
  localparam logic signed [16:0] RST_ENC_OFFSET  = -17'sd32127;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ADC_LOW,
    REG_ADC_HIGH,
    REG_FILTER_GAIN,
    REG_ENABLE_LEVEL,
    REG_FULL_TORQUE,
    REG_ENC_OFFSET
  } cfg_reg_t;

  typedef struct packed {
    logic [11:0]        adc_low;
    logic [11:0]        adc_high;
    logic [16:0]        filter_gain;
    logic [15:0]        enable_level;
    logic [15:0]        full_torque;
    logic signed [16:0] enc_offset;
  } cfg_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_STEP,
    OP_FILT_MUL,
    OP_FILT_ADD,
    OP_EFF_SETUP,
    OP_TRQ_MUL,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== design/ptce_in_if.sv =====
// Sample channel interface: valid, ready and the raw ADC sample.
`default_nettype none
interface ptce_in_if #(
  parameter int ADC_BITS = 12
);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface
`default_nettype wire

// ===== design/ptce_out_if.sv =====
// Result channel interface: valid, ready, encoded torque field, filtered level and active flag.
`default_nettype none
interface ptce_out_if #(
  parameter int FIELD_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] torque_field;
  logic [16:0]           filtered_level_out;
  logic                  torque_active;

  modport source (output valid, output torque_field, output filtered_level_out,
                  output torque_active, input ready);
  modport sink (input valid, input torque_field, input filtered_level_out,
                input torque_active, output ready);
endinterface
`default_nettype wire

// ===== design/pedal_torque_command_encoder.sv =====
// Top level of the pedal torque command encoder.
//
// One transfer on in_ch carries a raw pedal ADC sample. For each sample the
// block produces exactly one transfer on out_ch with the encoded torque field
// (all ones when no torque is available), the updated filtered pedal level
// in Q16 and a flag that is set when a torque value was encoded.
// Configuration registers are written through cfg_we, cfg_idx and cfg_data
// only while no sample is in flight, a rule for the user that the block does
// not enforce; unknown indexes are ignored. A sample is processed as two
// 16-bit divisions on one shared divider that retires four quotient bits per
// cycle, two multiplies and a few control steps. A new sample is taken only
// once the previous result has been written to the output register.
// The result sits in an output register, so the next sample is accepted while
// it waits; if the receiver stalls, the following result waits in its last
// step until the register is free. Synchronous reset restores the register
// defaults and clears the filtered level and the output valid.
`default_nettype none
module pedal_torque_command_encoder
  import ptce_pkg::*;
#(
  parameter int ADC_BITS   = ADC_BITS_DEF,
  parameter int FIELD_BITS = FIELD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  ptce_in_if.sink                    in_ch,
  ptce_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  ptce_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  ptce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  ptce_dp #(
    .ADC_BITS   (ADC_BITS),
    .FIELD_BITS (FIELD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .cfg        (cfg),
    .in_sample  (in_ch.adc_sample),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_field  (out_ch.torque_field),
    .out_level  (out_ch.filtered_level_out),
    .out_active (out_ch.torque_active)
  );

endmodule
`default_nettype wire

// ===== design/ptce_cfg_regs.sv =====
// Configuration register file written through the plain write port.
`default_nettype none
module ptce_cfg_regs
  import ptce_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_ADC_LOW:      cfg_nxt.adc_low      = cfg_data[11:0];
        REG_ADC_HIGH:     cfg_nxt.adc_high     = cfg_data[11:0];
        REG_FILTER_GAIN:  cfg_nxt.filter_gain  = cfg_data[16:0];
        REG_ENABLE_LEVEL: cfg_nxt.enable_level = cfg_data[15:0];
        REG_FULL_TORQUE:  cfg_nxt.full_torque  = cfg_data[15:0];
        REG_ENC_OFFSET:   cfg_nxt.enc_offset   = $signed(cfg_data[16:0]);
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.adc_low      <= RST_ADC_LOW;
      cfg_r.adc_high     <= RST_ADC_HIGH;
      cfg_r.filter_gain  <= RST_FILTER_GAIN;
      cfg_r.enable_level <= RST_ENABLE;
      cfg_r.full_torque  <= RST_FULL_TORQUE;
      cfg_r.enc_offset   <= RST_ENC_OFFSET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ===== design/ptce_dp.sv =====
// Datapath: shared radix-16 divider, multiplier, filter state and output register.
`default_nettype none
module ptce_dp
  import ptce_pkg::*;
#(
  parameter int ADC_BITS   = ADC_BITS_DEF,
  parameter int FIELD_BITS = FIELD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire dp_cmd_t               cmd,
  output dp_status_t                 status,
  input  wire cfg_t                  cfg,
  input  wire logic [ADC_BITS-1:0]   in_sample,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output logic [FIELD_BITS-1:0]      out_field,
  output logic [LEVEL_W-1:0]         out_level,
  output logic                       out_active
);

  localparam logic [LEVEL_W-1:0] ADC_MASK = LEVEL_W'((34'(1) << ADC_BITS) - 34'(1));
  localparam logic [33:0]        FIELD_LIM = 34'(1) << FIELD_BITS;

  logic [LEVEL_W-1:0]    rem_r, rem_nxt;
  logic [LEVEL_W-1:0]    den_r, den_nxt;
  logic [DIV_QBITS-1:0]  quo_r, quo_nxt;
  logic                  ovr_r, ovr_nxt;
  logic [LEVEL_W-1:0]    ovr_val_r, ovr_val_nxt;
  logic [LEVEL_W-1:0]    level_r, level_nxt;
  logic signed [35:0]    fprod_r, fprod_nxt;
  logic                  below_r, below_nxt;
  logic [31:0]           tprod_r, tprod_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [FIELD_BITS-1:0] field_r, field_nxt;
  logic [LEVEL_W-1:0]    olevel_r, olevel_nxt;
  logic                  active_r, active_nxt;

  logic [LEVEL_W-1:0]    s17, lo17, hi17;
  logic signed [17:0]    span, diff;
  logic [LEVEL_W-1:0]    div_res;
  logic signed [17:0]    delta;
  logic signed [35:0]    step_w, sum_w;
  logic [LEVEL_W-1:0]    num_e, den_e;
  logic [15:0]           counts;
  logic signed [18:0]    raw19;
  logic signed [33:0]    raw34;
  logic                  fits;
  logic [LEVEL_W-1:0]    r_it;
  logic [17:0]           t_it;
  logic [DIV_QBITS-1:0]  q_it;

  always_comb begin
    s17  = LEVEL_W'(in_sample);
    lo17 = LEVEL_W'(cfg.adc_low) & ADC_MASK;
    hi17 = LEVEL_W'(cfg.adc_high) & ADC_MASK;
    span = $signed({1'b0, hi17}) - $signed({1'b0, lo17});
    diff = $signed({1'b0, s17}) - $signed({1'b0, lo17});

    div_res = ovr_r ? ovr_val_r : LEVEL_W'(quo_r);
    delta   = $signed({1'b0, div_res}) - $signed({1'b0, level_r});

    if (fprod_r < 0) begin
      step_w = (fprod_r + 36'sd65535) >>> 16;
    end else begin
      step_w = fprod_r >>> 16;
    end
    sum_w = $signed({19'b0, level_r}) + step_w;

    num_e = level_r - {1'b0, cfg.enable_level};
    den_e = Q16_ONE - {1'b0, cfg.enable_level};

    counts = tprod_r[31:16];
    raw19  = $signed({3'b0, counts}) - $signed({{2{cfg.enc_offset[16]}}, cfg.enc_offset});
    raw34  = $signed({{15{raw19[18]}}, raw19});
    fits   = !raw34[33] && (raw34[32:0] < FIELD_LIM[32:0]);

    r_it = rem_r;
    q_it = quo_r;
    for (int k = 0; k < DIV_BITS_PER_STEP; k++) begin
      t_it = {r_it, 1'b0};
      if (t_it >= {1'b0, den_r}) begin
        t_it = t_it - {1'b0, den_r};
        q_it = {q_it[DIV_QBITS-2:0], 1'b1};
      end else begin
        q_it = {q_it[DIV_QBITS-2:0], 1'b0};
      end
      r_it = t_it[LEVEL_W-1:0];
    end
  end

  always_comb begin
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    quo_nxt       = quo_r;
    ovr_nxt       = ovr_r;
    ovr_val_nxt   = ovr_val_r;
    level_nxt     = level_r;
    fprod_nxt     = fprod_r;
    below_nxt     = below_r;
    tprod_nxt     = tprod_r;
    out_valid_nxt = out_valid_r;
    field_nxt     = field_r;
    olevel_nxt    = olevel_r;
    active_nxt    = active_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (cmd.op)
      OP_LOAD: begin
        rem_nxt = diff[LEVEL_W-1:0];
        den_nxt = span[LEVEL_W-1:0];
        quo_nxt = '0;
        if (span <= 0 || diff <= 0) begin
          ovr_nxt     = 1'b1;
          ovr_val_nxt = '0;
        end else if (diff >= span) begin
          ovr_nxt     = 1'b1;
          ovr_val_nxt = Q16_ONE;
        end else begin
          ovr_nxt = 1'b0;
        end
      end
      OP_DIV_STEP: begin
        rem_nxt = r_it;
        quo_nxt = q_it;
      end
      OP_FILT_MUL: begin
        fprod_nxt = $signed({1'b0, cfg.filter_gain}) * delta;
      end
      OP_FILT_ADD: begin
        if (sum_w < 0) begin
          level_nxt = '0;
        end else if (sum_w > $signed({19'b0, Q16_ONE})) begin
          level_nxt = Q16_ONE;
        end else begin
          level_nxt = sum_w[LEVEL_W-1:0];
        end
      end
      OP_EFF_SETUP: begin
        below_nxt = level_r < {1'b0, cfg.enable_level};
        rem_nxt   = num_e;
        den_nxt   = den_e;
        quo_nxt   = '0;
        if (num_e == den_e) begin
          ovr_nxt     = 1'b1;
          ovr_val_nxt = Q16_ONE;
        end else begin
          ovr_nxt = 1'b0;
        end
      end
      OP_TRQ_MUL: begin
        tprod_nxt = 32'(div_res) * 32'(cfg.full_torque);
      end
      OP_EMIT: begin
        out_valid_nxt = 1'b1;
        olevel_nxt    = level_r;
        if (!below_r && tprod_r != '0 && fits) begin
          active_nxt = 1'b1;
          field_nxt  = raw34[FIELD_BITS-1:0];
        end else begin
          active_nxt = 1'b0;
          field_nxt  = '1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r     <= rem_nxt;
    den_r     <= den_nxt;
    quo_r     <= quo_nxt;
    ovr_r     <= ovr_nxt;
    ovr_val_r <= ovr_val_nxt;
    fprod_r   <= fprod_nxt;
    below_r   <= below_nxt;
    tprod_r   <= tprod_nxt;
    field_r   <= field_nxt;
    olevel_r  <= olevel_nxt;
    active_r  <= active_nxt;
  end

  assign status.out_busy = out_valid_r && !out_ready;
  assign out_valid       = out_valid_r;
  assign out_field       = field_r;
  assign out_level       = olevel_r;
  assign out_active      = active_r;

endmodule
`default_nettype wire

// ===== design/ptce_ctrl.sv =====
// Controller state machine that sequences one sample through the datapath.
`default_nettype none
module ptce_ctrl
  import ptce_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_NDIV,
    S_FMUL,
    S_FADD,
    S_ESET,
    S_EDIV,
    S_TMUL,
    S_EMIT
  } state_t;

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd.op    = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          cnt_nxt   = '0;
          state_nxt = S_NDIV;
        end
      end
      S_NDIV: begin
        cmd.op  = OP_DIV_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_FMUL;
        end
      end
      S_FMUL: begin
        cmd.op    = OP_FILT_MUL;
        state_nxt = S_FADD;
      end
      S_FADD: begin
        cmd.op    = OP_FILT_ADD;
        state_nxt = S_ESET;
      end
      S_ESET: begin
        cmd.op    = OP_EFF_SETUP;
        cnt_nxt   = '0;
        state_nxt = S_EDIV;
      end
      S_EDIV: begin
        cmd.op  = OP_DIV_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_TMUL;
        end
      end
      S_TMUL: begin
        cmd.op    = OP_TRQ_MUL;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!status.out_busy) begin
          cmd.op    = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule
`default_nettype wire
